// File: src/iirdf_pkg.sv
`timescale 1ns / 1ps

package iirdf_pkg;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_MAX_ORDER      = 3;
   localparam int DEFAULT_SAMPLE_BITS    = 10;
   localparam int DEFAULT_COEF_FRAC_BITS = 14;

   // Fixed formats of the coefficient registers and of the output.
   localparam int COEF_W     = 16;
   localparam int OUT_BITS   = 18;
   localparam int OUT_FRAC   = 6;
   localparam int OUT_MAX    = 131071;
   localparam int OUT_MIN    = -131072;
   localparam int RSP_DATA_W = 24;

   // Register file layout: eight word registers.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORDER  = 3'd0,
      REG_FEED_0 = 3'd1,
      REG_FEED_1 = 3'd2,
      REG_FEED_2 = 3'd3,
      REG_FEED_3 = 3'd4,
      REG_BACK_1 = 3'd5,
      REG_BACK_2 = 3'd6,
      REG_BACK_3 = 3'd7
   } csr_reg_type;

   // Highest tap index that has a register of its own.
   localparam int CSR_MAX_TAP = 3;
   localparam logic [1:0] ORDER_RESET = 2'd3;

   // Reset value of the feedforward coefficient of tap k.
   function automatic logic [COEF_W-1:0] feed_reset(input int k);
      logic [COEF_W-1:0] v;
      case (k)
         0:       v = COEF_W'(811);
         1:       v = COEF_W'(2435);
         2:       v = COEF_W'(2435);
         3:       v = COEF_W'(811);
         default: v = '0;
      endcase
      return v;
   endfunction

   // Reset value of the feedback coefficient of tap k.
   function automatic logic [COEF_W-1:0] back_reset(input int k);
      logic [COEF_W-1:0] v;
      case (k)
         1:       v = COEF_W'(-19036);
         2:       v = COEF_W'(11402);
         3:       v = COEF_W'(-2258);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: src/iirdf_cell.sv
`timescale 1ns / 1ps

// One tap of the delay line: holds x[n-k] and y[n-k], keeps the registered
// feedforward (and, for the outer taps, feedback) product of its contents,
// and adds its contribution to the partial sum passing along the chain.
module iirdf_cell import iirdf_pkg::*; #(
   parameter int SAMPLE_BITS   = DEFAULT_SAMPLE_BITS,
   parameter int ACC_W         = 48,
   parameter bit LIVE_FEEDBACK = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift,
   input  logic                     enable,
   input  logic [SAMPLE_BITS-1:0]   x_prev,
   input  logic signed [OUT_BITS-1:0] y_prev,
   input  logic signed [COEF_W-1:0] feed_coef,
   input  logic signed [COEF_W-1:0] back_coef,
   input  logic signed [ACC_W-1:0]  sum_in,
   output logic [SAMPLE_BITS-1:0]   x_q,
   output logic signed [OUT_BITS-1:0] y_q,
   output logic signed [ACC_W-1:0]  sum_out
);

   localparam int FF_PROD_W = COEF_W + SAMPLE_BITS + 1;
   localparam int FB_PROD_W = COEF_W + OUT_BITS;

   logic [SAMPLE_BITS-1:0]      x_ff, x_in;
   logic signed [OUT_BITS-1:0]  y_ff, y_in;
   logic signed [FF_PROD_W-1:0] ff_prod;
   logic signed [ACC_W-1:0]     ff_term_ff, ff_term_in;
   logic signed [ACC_W-1:0]     fb_term;

   // History moves one place on each accepted transaction and holds otherwise.
   assign x_in = shift ? x_prev : x_ff;
   assign y_in = shift ? y_prev : y_ff;

   // The product is formed from the value the tap will hold next, so it is
   // ready in the cycle after the shift. While idle it is refreshed from the
   // tap's own contents, which picks up new coefficients.
   assign ff_prod    = feed_coef * $signed({1'b0, x_in});
   assign ff_term_in = ACC_W'(ff_prod) <<< OUT_FRAC;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff       <= '0;
         y_ff       <= '0;
         ff_term_ff <= '0;
      end else begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         ff_term_ff <= ff_term_in;
      end
   end

   generate
      if (LIVE_FEEDBACK) begin : g_live
         // Nearest tap: y[n-1] was only just registered, so its product sits in
         // the recursion itself.
         logic signed [FB_PROD_W-1:0] fb_prod;

         assign fb_prod = back_coef * y_ff;
         assign fb_term = -(ACC_W'(fb_prod));
      end else begin : g_reg
         logic signed [FB_PROD_W-1:0] fb_prod;
         logic signed [ACC_W-1:0]     fb_term_ff, fb_term_in;

         assign fb_prod    = back_coef * y_in;
         assign fb_term_in = -(ACC_W'(fb_prod));

         always_ff @(posedge clock) begin
            if (reset) begin
               fb_term_ff <= '0;
            end else begin
               fb_term_ff <= fb_term_in;
            end
         end

         assign fb_term = fb_term_ff;
      end
   endgenerate

   // Taps beyond the order in use contribute nothing but keep shifting.
   assign sum_out = enable ? (sum_in + ff_term_ff + fb_term) : sum_in;
   assign x_q     = x_ff;
   assign y_q     = y_ff;

endmodule

// File: src/iirdf_csr.sv
`timescale 1ns / 1ps

// Configuration registers: filter order and the Q2.x coefficients.
module iirdf_csr import iirdf_pkg::*; #(
   parameter int MAX_ORDER = DEFAULT_MAX_ORDER
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready,
   output logic [1:0]              order_in_use,
   output logic [MAX_ORDER:0][COEF_W-1:0] feed_coef,
   output logic [MAX_ORDER:1][COEF_W-1:0] back_coef,
   output logic                    written
);

   logic [1:0]                    order_ff;
   logic [MAX_ORDER:0][COEF_W-1:0] feed_ff;
   logic [MAX_ORDER:1][COEF_W-1:0] back_ff;
   logic [CSR_IDX_W-1:0]          reg_idx;
   logic                          wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   // Register writes; a coefficient without a tap in this build is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
         for (int k = 0; k <= MAX_ORDER; k++) begin
            feed_ff[k] <= feed_reset(k);
         end
         for (int k = 1; k <= MAX_ORDER; k++) begin
            back_ff[k] <= back_reset(k);
         end
      end else if (wr_en) begin
         if (reg_idx == REG_ORDER) begin
            order_ff <= pwdata[1:0];
         end
         for (int k = 0; k <= MAX_ORDER; k++) begin
            if (k <= CSR_MAX_TAP && reg_idx == REG_FEED_0 + CSR_IDX_W'(k)) begin
               feed_ff[k] <= pwdata[COEF_W-1:0];
            end
         end
         for (int k = 1; k <= MAX_ORDER; k++) begin
            if (k <= CSR_MAX_TAP && reg_idx == REG_BACK_1 + CSR_IDX_W'(k - 1)) begin
               back_ff[k] <= pwdata[COEF_W-1:0];
            end
         end
      end
   end

   // Read back; coefficients are returned sign-extended.
   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_ORDER: prdata = CSR_DATA_W'(order_ff);
         default:   prdata = '0;
      endcase
      for (int k = 0; k <= MAX_ORDER; k++) begin
         if (k <= CSR_MAX_TAP && reg_idx == REG_FEED_0 + CSR_IDX_W'(k)) begin
            prdata = CSR_DATA_W'(signed'(feed_ff[k]));
         end
      end
      for (int k = 1; k <= MAX_ORDER; k++) begin
         if (k <= CSR_MAX_TAP && reg_idx == REG_BACK_1 + CSR_IDX_W'(k - 1)) begin
            prdata = CSR_DATA_W'(signed'(back_ff[k]));
         end
      end
   end

   assign order_in_use = order_ff;
   assign feed_coef    = feed_ff;
   assign back_coef    = back_ff;
   assign written      = wr_en;

endmodule

// File: src/iir_direct_form_filter_core.sv
`timescale 1ns / 1ps

// Direct form I IIR filter of order 1 to 3 for unsigned ADC samples. Each
// sample transaction yields one result transaction, y[n] = sum b_k*x[n-k]
// - sum a_k*y[n-k], with 6 fraction bits, rounded half up and saturated to
// 18 bits signed; tuser flags a saturated result. The block takes one sample
// per clock cycle while the result is taken and no register write holds it
// off; the result shows in the next cycle in an output register. A new
// sample is taken in the same cycle as the waiting result is accepted, and
// the input stalls for as long as the result is held off. The rate is set by
// the recursion through the nearest tap: the a1*y[n-1] product, the
// partial-sum chain of the taps, rounding and saturation all form one
// combinational path. The other products, apart from b0*x[n], are formed
// ahead and registered in their taps. After any register write the input
// is held not ready while the taps refresh their products with the new
// coefficients. An order of 0 acts as 1; all history shifts, whatever order.
module iir_direct_form_filter_core import iirdf_pkg::*; #(
   parameter int MAX_ORDER      = DEFAULT_MAX_ORDER,
   parameter int SAMPLE_BITS    = DEFAULT_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = DEFAULT_COEF_FRAC_BITS,
   localparam int REQ_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Sample channel; tdata: [SAMPLE_BITS-1:0] sample
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Result channel; tdata: [17:0] filtered; tuser: [0] clipped
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int FF_W   = COEF_W + SAMPLE_BITS + 1 + OUT_FRAC;
   localparam int FB_W   = COEF_W + OUT_BITS;
   localparam int MIN_W  = COEF_FRAC_BITS + OUT_BITS + 1;
   localparam int BASE_W = (FF_W > FB_W) ? ((FF_W > MIN_W) ? FF_W : MIN_W)
                                         : ((FB_W > MIN_W) ? FB_W : MIN_W);
   localparam int ACC_W  = BASE_W + $clog2(2 * MAX_ORDER + 3);
   localparam int YW     = ACC_W - COEF_FRAC_BITS;
   localparam int FF_PROD_W = COEF_W + SAMPLE_BITS + 1;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [YW-1:0]    Y_HI = YW'(OUT_MAX);
   localparam logic signed [YW-1:0]    Y_LO = YW'(OUT_MIN);

   logic [1:0]                     order_in_use;
   logic [MAX_ORDER:0][COEF_W-1:0] feed_coef;
   logic [MAX_ORDER:1][COEF_W-1:0] back_coef;
   logic                           csr_written;

   logic                           hold_ff, hold_in;
   logic                           accept;
   logic [SAMPLE_BITS-1:0]         sample;

   logic [SAMPLE_BITS-1:0]         x_link   [0:MAX_ORDER];
   logic signed [OUT_BITS-1:0]     y_link   [0:MAX_ORDER];
   logic signed [ACC_W-1:0]        sum_link [1:MAX_ORDER+1];
   logic [MAX_ORDER:1]             tap_en;

   logic signed [FF_PROD_W-1:0]    head_prod;
   logic signed [ACC_W-1:0]        acc;
   logic signed [YW-1:0]           y_wide;
   logic signed [OUT_BITS-1:0]     y_sat;
   logic                           clip;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]     rsp_filtered_ff;
   logic                           rsp_clipped_ff;

   iirdf_csr #(
      .MAX_ORDER (MAX_ORDER)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .order_in_use (order_in_use),
      .feed_coef    (feed_coef),
      .back_coef    (back_coef),
      .written      (csr_written)
   );

   // Back-pressure, through a registered flag, after a register write.
   assign hold_in = csr_written;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   assign req_tready = !hold_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign sample     = req_tdata[SAMPLE_BITS-1:0];

   // Tap chain: x and y enter at the near end, partial sums flow back to it.
   assign x_link[0]              = sample;
   assign y_link[0]              = y_sat;
   assign sum_link[MAX_ORDER+1]  = '0;

   generate
      for (genvar k = 1; k <= MAX_ORDER; k++) begin : g_tap
         // An order of 0 acts as 1; an order above the build's taps is capped
         // by the number of taps that exist.
         assign tap_en[k] = (k == 1) || (32'(order_in_use) >= 32'(k));

         iirdf_cell #(
            .SAMPLE_BITS   (SAMPLE_BITS),
            .ACC_W         (ACC_W),
            .LIVE_FEEDBACK (k == 1)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (accept),
            .enable    (tap_en[k]),
            .x_prev    (x_link[k-1]),
            .y_prev    (y_link[k-1]),
            .feed_coef (signed'(feed_coef[k])),
            .back_coef (signed'(back_coef[k])),
            .sum_in    (sum_link[k+1]),
            .x_q       (x_link[k]),
            .y_q       (y_link[k]),
            .sum_out   (sum_link[k])
         );
      end
   endgenerate

   // Current sample term, rounding and floor shift.
   assign head_prod = signed'(feed_coef[0]) * $signed({1'b0, sample});
   assign acc       = (ACC_W'(head_prod) <<< OUT_FRAC) + sum_link[1] + ROUND_HALF;
   assign y_wide    = acc[ACC_W-1:COEF_FRAC_BITS];

   // Saturation to the output range.
   always_comb begin
      if (y_wide > Y_HI) begin
         y_sat = OUT_BITS'(OUT_MAX);
         clip  = 1'b1;
      end else if (y_wide < Y_LO) begin
         y_sat = OUT_BITS'(OUT_MIN);
         clip  = 1'b1;
      end else begin
         y_sat = y_wide[OUT_BITS-1:0];
         clip  = 1'b0;
      end
   end

   // Output register.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_filtered_ff <= y_sat;
         rsp_clipped_ff  <= clip;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(unsigned'(rsp_filtered_ff));
   assign rsp_tuser  = rsp_clipped_ff;

   // A flagged result sits on one of the two rails.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clipped_ff |->
         (rsp_filtered_ff == OUT_BITS'(OUT_MAX)) || (rsp_filtered_ff == OUT_BITS'(OUT_MIN)))
      else $error("clipped result is not at a saturation rail");

   // No sample is taken in the cycle after a register write.
   assert property (@(posedge clock) disable iff (reset)
      csr_written |=> !req_tready)
      else $error("sample accepted before tap products were refreshed");

   // An accepted sample becomes the nearest history entry, with its result.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (x_link[1] == $past(sample)) && (y_link[1] == rsp_filtered_ff))
      else $error("history did not take the accepted sample and its result");

endmodule
